// ----- hw/rtl/fup_pkg.sv -----
// Package for the form-urlencoded stream parser: word types, decoder state,
// character and status codes, and the hex digit decode.
// No dependencies.
`timescale 1ns / 1ps

package fup_pkg;

  localparam int MAX_BYTES_W  = 24;
  localparam int MAX_FIELDS_W = 16;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BYTES  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FIELDS = 1'b1;

  localparam logic [MAX_BYTES_W-1:0]  MAX_BYTES_RST  = 24'd65536;
  localparam logic [MAX_FIELDS_W-1:0] MAX_FIELDS_RST = 16'd1000;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_ESCAPE = 2'd1;
  localparam logic [1:0] ST_TOO_MANY   = 2'd2;
  localparam logic [1:0] ST_TOO_LONG   = 2'd3;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] decoded_byte;
    logic       in_value;
    logic       field_end;
    logic       done_res;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    esc_phase_t              esc_phase;
    logic [3:0]              high_nibble;
    logic                    value_part;
    logic                    field_open;
    logic [MAX_FIELDS_W-1:0] field_count;
    logic [1:0]              first_error;
  } dec_state_t;

  // bit 4 flags a valid hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, c[3:0]};
      [8'h41:8'h46],
      [8'h61:8'h66]: r = {1'b1, 4'(c[3:0] + 4'd9)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/fup_decode.sv -----
// One-byte decode step of the form-urlencoded parser: next decoder state and
// the result word. Pure logic; depends on fup_pkg.
`timescale 1ns / 1ps

module fup_decode (
  input  fup_pkg::dec_state_t                  st,
  input  fup_pkg::in_word_t                    word,
  input  logic [fup_pkg::MAX_FIELDS_W-1:0]     max_fields,
  input  logic                                 len_exceeded,
  output fup_pkg::dec_state_t                  st_nxt,
  output fup_pkg::out_word_t                   res
);
  import fup_pkg::*;

  always_comb begin
    dec_state_t nx;
    logic [4:0] hx;
    logic       has;
    logic [7:0] dec;
    logic       part;
    logic       fend;
    logic       done;
    logic [1:0] status;

    nx     = st;
    hx     = hex_digit(word.data_byte);
    has    = 1'b0;
    dec    = 8'd0;
    part   = st.value_part;
    fend   = 1'b0;
    done   = 1'b0;
    status = ST_OK;

    if (word.data_byte == CH_AMP) begin
      if (st.esc_phase != ESC_NONE && nx.first_error == ST_OK) nx.first_error = ST_BAD_ESCAPE;
      fend          = st.field_open;
      nx.esc_phase  = ESC_NONE;
      nx.value_part = 1'b0;
      nx.field_open = 1'b0;
    end else begin
      if (!st.field_open) begin
        part = 1'b0;
        if (st.field_count == max_fields) begin
          if (nx.first_error == ST_OK) nx.first_error = ST_TOO_MANY;
        end else begin
          nx.field_count = st.field_count + 1'b1;
        end
        nx.field_open = 1'b1;
      end
      if (st.esc_phase != ESC_NONE) begin
        if (!hx[4]) begin
          if (nx.first_error == ST_OK) nx.first_error = ST_BAD_ESCAPE;
          nx.esc_phase = ESC_NONE;
        end else if (st.esc_phase == ESC_HIGH) begin
          nx.high_nibble = hx[3:0];
          nx.esc_phase   = ESC_LOW;
        end else begin
          has          = 1'b1;
          dec          = {st.high_nibble, hx[3:0]};
          nx.esc_phase = ESC_NONE;
        end
      end else if (word.data_byte == CH_PERCENT) begin
        nx.esc_phase = ESC_HIGH;
      end else if (word.data_byte == CH_EQUAL && !st.value_part) begin
        nx.value_part = 1'b1;
      end else begin
        has = 1'b1;
        dec = (word.data_byte == CH_PLUS) ? CH_SPACE : word.data_byte;
      end
    end

    if (word.last) begin
      if (nx.esc_phase != ESC_NONE && nx.first_error == ST_OK) nx.first_error = ST_BAD_ESCAPE;
      if (nx.field_open) fend = 1'b1;
      done   = 1'b1;
      status = len_exceeded ? ST_TOO_LONG : nx.first_error;
    end

    // drop output once the message is in error
    if (nx.first_error != ST_OK || len_exceeded) begin
      has  = 1'b0;
      dec  = 8'd0;
      fend = 1'b0;
    end

    res.has_byte     = has;
    res.decoded_byte = dec;
    res.in_value     = part;
    res.field_end    = fend;
    res.done_res     = done;
    res.status       = status;

    st_nxt = word.last ? dec_state_t'('0) : nx;
  end

endmodule

// ----- hw/rtl/form_urlencoded_stream_parser.sv -----
// Top level of the form-urlencoded stream parser: config registers, byte
// counter, decoder state and the result register. Depends on fup_pkg and
// fup_decode.
//
//   port group   dir  payload        handshake
//   in_*         in   in_word_t      in_valid / in_stall
//   out_*        out  out_word_t     out_valid / out_stall
//   cfg_*        in   index, data    cfg_we
//
// One byte per cycle while in_stall is low; each accepted byte yields exactly one result word, registered
// and valid in the cycle after it is accepted. The decode step, from decoder state register to result register,
// sets the rate. rst_n is synchronous: clears decoder state, counters and the result valid, and resets the limit
// registers to their defaults. in_stall is high only while a result waits and out_stall holds it.
`timescale 1ns / 1ps

module form_urlencoded_stream_parser #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fup_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fup_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [fup_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fup_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fup_pkg::*;

  localparam int CntW = LENGTH_BITS + 1;
  localparam int CmpW = (CntW > MAX_BYTES_W) ? CntW : MAX_BYTES_W;

  logic [MAX_BYTES_W-1:0]  max_bytes_r;
  logic [MAX_FIELDS_W-1:0] max_fields_r;
  logic [CntW-1:0]         cnt_r;
  logic [CntW-1:0]         cnt_nxt;
  logic                    len_r;
  logic                    len_nxt;
  dec_state_t              st_r;
  dec_state_t              st_nxt;
  out_word_t               res;
  logic                    out_valid_r;
  out_word_t               out_word_r;
  logic                    in_acc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // saturate the count at all ones
  assign cnt_nxt = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
  assign len_nxt = len_r || (CmpW'(cnt_nxt) > CmpW'(max_bytes_r));

  fup_decode u_decode (
    .st           (st_r),
    .word         (in_word),
    .max_fields   (max_fields_r),
    .len_exceeded (len_nxt),
    .st_nxt       (st_nxt),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r  <= MAX_BYTES_RST;
      max_fields_r <= MAX_FIELDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_BYTES:  max_bytes_r  <= cfg_wdata[MAX_BYTES_W-1:0];
        REG_MAX_FIELDS: max_fields_r <= cfg_wdata[MAX_FIELDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      len_r       <= 1'b0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r       <= in_word.last ? '0 : cnt_nxt;
        len_r       <= in_word.last ? 1'b0 : len_nxt;
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted word produced no result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_word.last |=> cnt_r == '0 && !len_r && st_r.field_count == '0)
    else $error("message state not cleared after last word");

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.done_res |-> out_word_r.status == ST_OK)
    else $error("status reported without done");

  a_err_mutes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.done_res && out_word_r.status != ST_OK
      |-> !out_word_r.has_byte && !out_word_r.field_end)
    else $error("decoded byte emitted on an errored message");

endmodule

// ----- sim/tb.sv -----
// Testbench for form_urlencoded_stream_parser: a scripted opening message set, then random
// form bodies under several limit settings, checked word by word against a local decoder or,
// for typed script rows, their own expected words. Depends on fup_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb;
  import fup_pkg::*;

  localparam int LEN_BITS = 24;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } script_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  in_word_t                in_word = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_word_t               out_word;
  logic                    cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  // decoder copy
  logic [MAX_BYTES_W-1:0]  lim_bytes;
  logic [MAX_FIELDS_W-1:0] lim_fields;
  esc_phase_t              p_esc;
  logic [3:0]              p_high;
  logic                    p_value;
  logic                    p_open;
  logic [MAX_FIELDS_W-1:0] p_fields;
  logic [LEN_BITS:0]       p_count;
  logic [1:0]              p_error;
  logic                    p_too_long;

  out_word_t               expected_decodes[$];
  logic [7:0]              msg_body[$];
  int                      mismatches = 0;
  int                      phase_words = 0;
  int                      stall_left = 0;
  bit                      calm = 1'b0;
  bit                      pause_due = 1'b0;

  script_row_t script [25] = '{
    '{{8'h61, 1'b0}, 1'b1, {1'b1, 8'h61, 1'b0, 1'b0, 1'b0, ST_OK}},
    '{{CH_EQUAL, 1'b0}, 1'b0, '0},
    '{{CH_PERCENT, 1'b0}, 1'b0, '0},
    '{{8'h34, 1'b0}, 1'b0, '0},
    '{{8'h31, 1'b0}, 1'b0, '0},
    '{{CH_PLUS, 1'b0}, 1'b0, '0},
    '{{CH_EQUAL, 1'b0}, 1'b0, '0},
    '{{CH_AMP, 1'b0}, 1'b1, {1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_OK}},
    '{{CH_AMP, 1'b0}, 1'b0, '0},
    '{{CH_PERCENT, 1'b0}, 1'b0, '0},
    '{{8'h66, 1'b0}, 1'b0, '0},
    '{{8'h46, 1'b0}, 1'b0, '0},
    '{{8'hFF, 1'b1}, 1'b1, {1'b1, 8'hFF, 1'b0, 1'b1, 1'b1, ST_OK}},
    '{{CH_PERCENT, 1'b0}, 1'b0, '0},
    '{{8'h67, 1'b0}, 1'b0, '0},
    '{{8'h00, 1'b1}, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_BAD_ESCAPE}},
    '{{CH_PERCENT, 1'b1}, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_BAD_ESCAPE}},
    '{{CH_AMP, 1'b1}, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_OK}},
    '{{8'h71, 1'b0}, 1'b0, '0},
    '{{CH_PERCENT, 1'b0}, 1'b0, '0},
    '{{CH_AMP, 1'b0}, 1'b0, '0},
    '{{8'h72, 1'b1}, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_BAD_ESCAPE}},
    '{{CH_PERCENT, 1'b0}, 1'b0, '0},
    '{{8'h41, 1'b0}, 1'b0, '0},
    '{{CH_EQUAL, 1'b1}, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ST_BAD_ESCAPE}}
  };

  form_urlencoded_stream_parser #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_message();
    p_esc      = ESC_NONE;
    p_high     = 4'd0;
    p_value    = 1'b0;
    p_open     = 1'b0;
    p_fields   = '0;
    p_count    = '0;
    p_error    = ST_OK;
    p_too_long = 1'b0;
  endfunction

  function automatic void note_error(input logic [1:0] code);
    if (p_error == ST_OK) p_error = code;
  endfunction

  function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_word_t decode_byte(input in_word_t w);
    out_word_t  r;
    logic [3:0] nib;
    logic [7:0] c;
    r = '0;
    c = w.data_byte;
    r.in_value = p_value;
    if (p_count != '1) p_count = p_count + 1'b1;
    if (p_count > {1'b0, lim_bytes}) p_too_long = 1'b1;
    if (c == CH_AMP) begin
      if (p_esc != ESC_NONE) note_error(ST_BAD_ESCAPE);
      if (p_open) r.field_end = 1'b1;
      p_esc   = ESC_NONE;
      p_value = 1'b0;
      p_open  = 1'b0;
    end else begin
      if (!p_open) begin
        r.in_value = 1'b0;
        if (p_fields == lim_fields) note_error(ST_TOO_MANY);
        else p_fields = p_fields + 1'b1;
        p_open = 1'b1;
      end
      if (p_esc != ESC_NONE) begin
        if (!hex_value(c, nib)) begin
          note_error(ST_BAD_ESCAPE);
          p_esc = ESC_NONE;
        end else if (p_esc == ESC_HIGH) begin
          p_high = nib;
          p_esc  = ESC_LOW;
        end else begin
          r.has_byte     = 1'b1;
          r.decoded_byte = {p_high, nib};
          p_esc          = ESC_NONE;
        end
      end else if (c == CH_PERCENT) begin
        p_esc = ESC_HIGH;
      end else if (c == CH_EQUAL && !p_value) begin
        p_value = 1'b1;
      end else begin
        r.has_byte     = 1'b1;
        r.decoded_byte = (c == CH_PLUS) ? CH_SPACE : c;
      end
    end
    if (w.last) begin
      if (p_esc != ESC_NONE) note_error(ST_BAD_ESCAPE);
      if (p_open) r.field_end = 1'b1;
      r.done_res = 1'b1;
      r.status   = p_too_long ? ST_TOO_LONG : p_error;
    end
    if (p_error != ST_OK || p_too_long) begin
      r.has_byte     = 1'b0;
      r.decoded_byte = 8'h00;
      r.field_end    = 1'b0;
    end
    if (w.last) clear_message();
    return r;
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_decodes.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = expected_decodes.pop_front();
        check_field("has_byte", 8'(out_word.has_byte), 8'(want.has_byte));
        check_field("decoded_byte", out_word.decoded_byte, want.decoded_byte);
        check_field("in_value", 8'(out_word.in_value), 8'(want.in_value));
        check_field("field_end", 8'(out_word.field_end), 8'(want.field_end));
        check_field("done_res", 8'(out_word.done_res), 8'(want.done_res));
        check_field("status", 8'(out_word.status), 8'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t guess;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    guess = decode_byte(w);
    if (typed) guess = want;
    expected_decodes = {expected_decodes, guess};
    phase_words++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_decodes.size() != 0);
  endtask

  task automatic write_limits(input logic [23:0] bytes_lim, input logic [15:0] fields_lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_BYTES;
    cfg_wdata <= bytes_lim;
    @(posedge clk);
    cfg_index <= REG_MAX_FIELDS;
    cfg_wdata <= {8'($urandom), fields_lim};
    @(posedge clk);
    cfg_we     <= 1'b0;
    lim_bytes  = bytes_lim;
    lim_fields = fields_lim;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    msg_body = {msg_body, b};
  endfunction

  function automatic void add_char();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      put_byte(CH_PLUS);
    end else if (pick < 6) begin
      put_byte(CH_PERCENT);
      put_byte(hex_char(4'($urandom)));
      put_byte(hex_char(4'($urandom)));
    end else if (pick == 6) begin
      put_byte(CH_PERCENT);
      if ($urandom_range(0, 1)) put_byte(8'($urandom));
    end else if (pick == 7) begin
      put_byte(CH_EQUAL);
    end else if (pick == 8) begin
      put_byte(8'($urandom));
    end else begin
      put_byte(8'($urandom_range(8'h21, 8'h7E)));
    end
  endfunction

  task automatic send_message();
    int fields;
    msg_body.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
    end else begin
      fields = $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) put_byte(CH_AMP);
      for (int f = 0; f < fields; f++) begin
        if (f != 0) put_byte(CH_AMP);
        if ($urandom_range(0, 7) != 0) begin
          repeat ($urandom_range(0, 3)) add_char();
          if ($urandom_range(0, 9) < 7) begin
            put_byte(CH_EQUAL);
            repeat ($urandom_range(0, 4)) add_char();
          end
        end
      end
      if ($urandom_range(0, 7) == 0) put_byte(CH_AMP);
      if (msg_body.size() == 0) put_byte(8'($urandom));
    end
    foreach (msg_body[i]) begin
      // hold off mid-message until the pipe is empty
      if (pause_due && i == 2) begin
        wait_idle();
        pause_due = 1'b0;
      end
      push_word({msg_body[i], 1'(i == msg_body.size() - 1)}, 1'b0, '0);
    end
  endtask

  initial begin
    lim_bytes  = MAX_BYTES_RST;
    lim_fields = MAX_FIELDS_RST;
    clear_message();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (script[i]) push_word(script[i].word, script[i].typed, script[i].want);
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      repeat (3) @(posedge clk);
      case (ph)
        0:       write_limits(24'd0, 16'hFFFF);
        1:       write_limits(24'hFFFFFF, 16'd0);
        6:       write_limits(MAX_BYTES_RST, MAX_FIELDS_RST);
        default: write_limits(24'($urandom_range(1, 48)), 16'($urandom_range(1, 5)));
      endcase
      calm        = (ph == 7);
      pause_due   = (ph == 3);
      phase_words = 0;
      while (phase_words < 190) send_message();
    end
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
